// ===== hw/rtl/point_world_to_screen_transform_assert.svh =====
// Assertion macros for the point world-to-screen transform checker.
// No dependencies; included by the checker file only.
`ifndef POINT_WORLD_TO_SCREEN_TRANSFORM_ASSERT_SVH
`define POINT_WORLD_TO_SCREEN_TRANSFORM_ASSERT_SVH

// same-cycle implication, disabled in reset
`define PWST_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pwst check failed");

// next-cycle implication, disabled in reset
`define PWST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pwst check failed");

// next-cycle implication, live in reset
`define PWST_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("pwst check failed");

`endif

// ===== hw/rtl/pwst_pkg.sv =====
// Shared constants, types and helper functions for the point transform.
// No dependencies; imported by the divider, the CORDIC, the top level and the testbench.
`default_nettype none
package pwst_pkg;

    localparam int FRAC_BITS      = 16;
    localparam int MID_BITS       = 38;
    localparam int TRIG_STEPS_DEF = 16;
    localparam int TRIG_TABLE_LEN = 24;
    localparam int SAT_IN_W       = 72;
    localparam int VIEW_W         = 14;
    localparam int DIV_RPS        = 2;

    localparam int IN_TDATA_W  = 216;
    localparam int OUT_TDATA_W = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic signed [30:0] THETA_K     = 31'sd843289985;
    localparam longint             PI_Q        = 843314857;
    localparam longint             TWO_PI_Q    = 1686629713;
    localparam longint             HALF_PI_Q   = 421657428;
    localparam logic signed [31:0] CORDIC_GAIN = 32'sd163008219;

    localparam longint MID_MAX = (longint'(1) <<< (MID_BITS - 1)) - 1;
    localparam longint OUT_MAX = 2147483647;

    localparam logic [31:0]       RST_CAM_SCALE = 32'd65536;
    localparam logic [31:0]       RST_CAM_POS   = 32'd0;
    localparam logic [VIEW_W-1:0] RST_VIEW_W    = 14'd1280;
    localparam logic [VIEW_W-1:0] RST_VIEW_H    = 14'd720;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAM_SCALE_X = 3'd0,
        CFG_CAM_SCALE_Y = 3'd1,
        CFG_CAM_POS_X   = 3'd2,
        CFG_CAM_POS_Y   = 3'd3,
        CFG_VIEW_W      = 3'd4,
        CFG_VIEW_H      = 3'd5
    } t_cfg_idx;

    function automatic logic [27:0] atan_q28(input int i);
        logic [27:0] v;
        unique case (i)
            0:  v = 28'd210828714;
            1:  v = 28'd124459457;
            2:  v = 28'd65760959;
            3:  v = 28'd33381290;
            4:  v = 28'd16755422;
            5:  v = 28'd8385879;
            6:  v = 28'd4193963;
            7:  v = 28'd2097109;
            8:  v = 28'd1048571;
            9:  v = 28'd524287;
            10: v = 28'd262144;
            11: v = 28'd131072;
            12: v = 28'd65536;
            13: v = 28'd32768;
            14: v = 28'd16384;
            15: v = 28'd8192;
            16: v = 28'd4096;
            17: v = 28'd2048;
            18: v = 28'd1024;
            19: v = 28'd512;
            20: v = 28'd256;
            21: v = 28'd128;
            22: v = 28'd64;
            23: v = 28'd32;
            default: v = 28'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [MID_BITS-1:0] sat_mid(
        input logic signed [SAT_IN_W-1:0] v
    );
        logic signed [SAT_IN_W-1:0] hi;
        logic signed [SAT_IN_W-1:0] lo;
        hi = SAT_IN_W'(MID_MAX);
        lo = ~hi;
        if (v > hi) begin
            return MID_BITS'(hi);
        end else if (v < lo) begin
            return MID_BITS'(lo);
        end
        return MID_BITS'(v);
    endfunction

    function automatic logic signed [31:0] sat_out(input logic signed [SAT_IN_W-1:0] v);
        logic signed [SAT_IN_W-1:0] hi;
        logic signed [SAT_IN_W-1:0] lo;
        hi = SAT_IN_W'(OUT_MAX);
        lo = ~hi;
        if (v > hi) begin
            return 32'(hi);
        end else if (v < lo) begin
            return 32'(lo);
        end
        return 32'(v);
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/pwst_div.sv =====
// Pipelined two-lane unsigned restoring divider, DIV_RPS quotient bits per stage.
// Depends on pwst_pkg.
`default_nettype none
module pwst_div #(
    parameter int DW  = 54,
    parameter int VW  = 32,
    parameter int SW  = 2,
    parameter int RPS = pwst_pkg::DIV_RPS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [DW-1:0] i_num [2],
    input  logic [VW-1:0] i_den [2],
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [DW-1:0] o_quot [2],
    output logic [SW-1:0] o_side
);
    import pwst_pkg::*;

    localparam int STG = (DW + RPS - 1) / RPS;
    localparam int PW  = STG * RPS;

    logic          r_v    [STG];
    logic [VW-1:0] r_rem  [STG][2];
    logic [PW-1:0] r_dq   [STG][2];
    logic [VW-1:0] r_dv   [STG][2];
    logic [SW-1:0] r_side [STG];

    for (genvar g = 0; g < STG; g++) begin : g_stage
        logic          p_v;
        logic [VW-1:0] p_rem [2];
        logic [PW-1:0] p_dq  [2];
        logic [VW-1:0] p_dv  [2];
        logic [SW-1:0] p_side;
        logic [VW-1:0] n_rem [2];
        logic [PW-1:0] n_dq  [2];

        if (g == 0) begin : g_first
            assign p_v    = i_valid;
            assign p_side = i_side;
            for (genvar l = 0; l < 2; l++) begin : g_lane
                assign p_rem[l] = '0;
                assign p_dq[l]  = PW'(i_num[l]);
                assign p_dv[l]  = i_den[l];
            end
        end else begin : g_next
            assign p_v    = r_v[g-1];
            assign p_side = r_side[g-1];
            for (genvar l = 0; l < 2; l++) begin : g_lane
                assign p_rem[l] = r_rem[g-1][l];
                assign p_dq[l]  = r_dq[g-1][l];
                assign p_dv[l]  = r_dv[g-1][l];
            end
        end

        always_comb begin
            logic [VW-1:0] rem;
            logic [PW-1:0] dq;
            logic [VW:0]   trial;
            logic          qb;
            for (int l = 0; l < 2; l++) begin
                rem = p_rem[l];
                dq  = p_dq[l];
                for (int k = 0; k < RPS; k++) begin
                    trial = {rem, dq[PW-1]};
                    if (trial >= {1'b0, p_dv[l]}) begin
                        rem = VW'(trial - {1'b0, p_dv[l]});
                        qb  = 1'b1;
                    end else begin
                        rem = trial[VW-1:0];
                        qb  = 1'b0;
                    end
                    dq = {dq[PW-2:0], qb};
                end
                n_rem[l] = rem;
                n_dq[l]  = dq;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[g] <= p_side;
                for (int l = 0; l < 2; l++) begin
                    r_rem[g][l] <= n_rem[l];
                    r_dq[g][l]  <= n_dq[l];
                    r_dv[g][l]  <= p_dv[l];
                end
            end
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= p_v;
            end
        end
    end

    assign o_valid   = r_v[STG-1];
    assign o_side    = r_side[STG-1];
    assign o_quot[0] = DW'(r_dq[STG-1][0]);
    assign o_quot[1] = DW'(r_dq[STG-1][1]);

endmodule
`default_nettype wire

// ===== hw/rtl/pwst_cordic.sv =====
// Pipelined rotation-mode CORDIC, one micro-rotation per stage, Q.28 angle.
// Depends on pwst_pkg for the gain and the arctangent table.
`default_nettype none
module pwst_cordic #(
    parameter int STEPS = pwst_pkg::TRIG_STEPS_DEF,
    parameter int SW    = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic signed [31:0] i_z,
    input  logic [SW-1:0]      i_side,
    output logic               o_valid,
    output logic signed [31:0] o_x,
    output logic signed [31:0] o_y,
    output logic [SW-1:0]      o_side
);
    import pwst_pkg::*;

    logic               r_v    [STEPS];
    logic signed [31:0] r_x    [STEPS];
    logic signed [31:0] r_y    [STEPS];
    logic signed [31:0] r_z    [STEPS];
    logic [SW-1:0]      r_side [STEPS];

    for (genvar g = 0; g < STEPS; g++) begin : g_stage
        logic               p_v;
        logic signed [31:0] p_x;
        logic signed [31:0] p_y;
        logic signed [31:0] p_z;
        logic [SW-1:0]      p_side;
        logic signed [31:0] n_x;
        logic signed [31:0] n_y;
        logic signed [31:0] n_z;
        logic signed [31:0] ang;

        if (g == 0) begin : g_first
            assign p_v    = i_valid;
            assign p_x    = CORDIC_GAIN;
            assign p_y    = '0;
            assign p_z    = i_z;
            assign p_side = i_side;
        end else begin : g_next
            assign p_v    = r_v[g-1];
            assign p_x    = r_x[g-1];
            assign p_y    = r_y[g-1];
            assign p_z    = r_z[g-1];
            assign p_side = r_side[g-1];
        end

        assign ang = $signed({4'b0000, atan_q28(g)});

        always_comb begin
            if (p_z >= 0) begin
                n_x = p_x - (p_y >>> g);
                n_y = p_y + (p_x >>> g);
                n_z = p_z - ang;
            end else begin
                n_x = p_x + (p_y >>> g);
                n_y = p_y - (p_x >>> g);
                n_z = p_z + ang;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[g]    <= n_x;
                r_y[g]    <= n_y;
                r_z[g]    <= n_z;
                r_side[g] <= p_side;
            end
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= p_v;
            end
        end
    end

    assign o_valid = r_v[STEPS-1];
    assign o_x     = r_x[STEPS-1];
    assign o_y     = r_y[STEPS-1];
    assign o_side  = r_side[STEPS-1];

endmodule
`default_nettype wire

// ===== hw/rtl/point_world_to_screen_transform.sv =====
// Point world-to-screen transform: takes one point per clock and returns one screen
// point per clock while the output buffer is not full. The pipe runs through the input
// stages, the CORDIC stages, the two pipelined dividers (27 and 26 stages) and the
// output stages. A two-entry output buffer lets the pipe move on by one more result
// when the output stalls; the input stalls only while that buffer is full.
// Depends on pwst_pkg, pwst_cordic and pwst_div.
`default_nettype none
module point_world_to_screen_transform #(
    parameter int TRIG_STEPS = pwst_pkg::TRIG_STEPS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // local_x, local_y, obj_scale_x, obj_scale_y, rotate_turns, obj_pos_x, obj_pos_y
    input  logic [pwst_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // screen_x, screen_y
    output logic [pwst_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    // camera_singular
    output logic [0:0]                       o_m_axis_tuser,
    input  logic                             i_cfg_we,
    input  logic [pwst_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [pwst_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import pwst_pkg::*;

    localparam int SIDE_W = 1 + 2 * MID_BITS + 64;
    localparam int D1_W   = MID_BITS + FRAC_BITS;
    localparam int D2_W   = MID_BITS + VIEW_W;

    // configuration
    logic signed [31:0] r_cam_sx, r_cam_sy, r_cam_px, r_cam_py;
    logic [VIEW_W-1:0]  r_view_w, r_view_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_sx <= RST_CAM_SCALE;
            r_cam_sy <= RST_CAM_SCALE;
            r_cam_px <= RST_CAM_POS;
            r_cam_py <= RST_CAM_POS;
            r_view_w <= RST_VIEW_W;
            r_view_h <= RST_VIEW_H;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_CAM_SCALE_X: r_cam_sx <= i_cfg_data;
                CFG_CAM_SCALE_Y: r_cam_sy <= i_cfg_data;
                CFG_CAM_POS_X:   r_cam_px <= i_cfg_data;
                CFG_CAM_POS_Y:   r_cam_py <= i_cfg_data;
                CFG_VIEW_W:      r_view_w <= i_cfg_data[VIEW_W-1:0];
                CFG_VIEW_H:      r_view_h <= i_cfg_data[VIEW_W-1:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic r_skid_v;
    assign en              = !r_skid_v;
    assign o_s_axis_tready = en;

    // input fields
    logic signed [31:0] in_lx, in_ly, in_sx, in_sy, in_px, in_py;
    logic signed [17:0] in_rt;
    assign in_lx = i_s_axis_tdata[31:0];
    assign in_ly = i_s_axis_tdata[63:32];
    assign in_sx = i_s_axis_tdata[95:64];
    assign in_sy = i_s_axis_tdata[127:96];
    assign in_rt = i_s_axis_tdata[145:128];
    assign in_px = i_s_axis_tdata[177:146];
    assign in_py = i_s_axis_tdata[209:178];

    // stage 1: angle and local scale products
    logic               r1_v;
    logic signed [48:0] r1_tp;
    logic signed [63:0] r1_axp, r1_ayp;
    logic signed [31:0] r1_px, r1_py;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_tp  <= in_rt * THETA_K;
            r1_axp <= in_lx * in_sx;
            r1_ayp <= in_ly * in_sy;
            r1_px  <= in_px;
            r1_py  <= in_py;
        end
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_s_axis_tvalid;
        end
    end

    // stage 2: wrap angle into plus or minus pi, saturate scaled point
    logic signed [48:0]         t_sh;
    logic signed [31:0]         n2_t;
    logic                       r2_v;
    logic signed [31:0]         r2_t;
    logic signed [MID_BITS-1:0] r2_ax, r2_ay;
    logic signed [31:0]         r2_px, r2_py;

    assign t_sh = r1_tp >>> FRAC_BITS;

    always_comb begin
        if (t_sh > PI_Q) begin
            n2_t = 32'(t_sh - TWO_PI_Q);
        end else if (t_sh < -PI_Q) begin
            n2_t = 32'(t_sh + TWO_PI_Q);
        end else begin
            n2_t = 32'(t_sh);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_t  <= n2_t;
            r2_ax <= sat_mid(SAT_IN_W'(r1_axp >>> FRAC_BITS));
            r2_ay <= sat_mid(SAT_IN_W'(r1_ayp >>> FRAC_BITS));
            r2_px <= r1_px;
            r2_py <= r1_py;
        end
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
    end

    // stage 3: fold into plus or minus half pi
    logic signed [31:0]         n3_t;
    logic                       n3_flip;
    logic                       r3_v;
    logic signed [31:0]         r3_t;
    logic                       r3_flip;
    logic signed [MID_BITS-1:0] r3_ax, r3_ay;
    logic signed [31:0]         r3_px, r3_py;

    always_comb begin
        if (r2_t > HALF_PI_Q) begin
            n3_t    = 32'(r2_t - PI_Q);
            n3_flip = 1'b1;
        end else if (r2_t < -HALF_PI_Q) begin
            n3_t    = 32'(r2_t + PI_Q);
            n3_flip = 1'b1;
        end else begin
            n3_t    = r2_t;
            n3_flip = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_t    <= n3_t;
            r3_flip <= n3_flip;
            r3_ax   <= r2_ax;
            r3_ay   <= r2_ay;
            r3_px   <= r2_px;
            r3_py   <= r2_py;
        end
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= r2_v;
        end
    end

    // CORDIC
    logic                       c_v;
    logic signed [31:0]         c_x, c_y;
    logic [SIDE_W-1:0]          c_side;
    logic                       c_flip;
    logic signed [MID_BITS-1:0] c_ax, c_ay;
    logic signed [31:0]         c_px, c_py;

    pwst_cordic #(
        .STEPS (TRIG_STEPS),
        .SW    (SIDE_W)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r3_v),
        .i_z     (r3_t),
        .i_side  ({r3_flip, r3_ax, r3_ay, r3_px, r3_py}),
        .o_valid (c_v),
        .o_x     (c_x),
        .o_y     (c_y),
        .o_side  (c_side)
    );

    assign {c_flip, c_ax, c_ay, c_px, c_py} = c_side;

    // stage 4: cosine and sine to Q.22
    logic                       r4_v;
    logic signed [25:0]         r4_c, r4_s;
    logic signed [MID_BITS-1:0] r4_ax, r4_ay;
    logic signed [31:0]         r4_px, r4_py;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_c  <= 26'((c_flip ? -c_x : c_x) >>> 6);
            r4_s  <= 26'((c_flip ? -c_y : c_y) >>> 6);
            r4_ax <= c_ax;
            r4_ay <= c_ay;
            r4_px <= c_px;
            r4_py <= c_py;
        end
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (en) begin
            r4_v <= c_v;
        end
    end

    // stage 5: rotation products
    logic               r5_v;
    logic signed [63:0] r5_xc, r5_ys, r5_xs, r5_yc;
    logic signed [31:0] r5_px, r5_py;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_xc <= r4_ax * r4_c;
            r5_ys <= r4_ay * r4_s;
            r5_xs <= r4_ax * r4_s;
            r5_yc <= r4_ay * r4_c;
            r5_px <= r4_px;
            r5_py <= r4_py;
        end
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (en) begin
            r5_v <= r4_v;
        end
    end

    // stage 6: world point
    logic signed [64:0]         rot_x, rot_y;
    logic                       r6_v;
    logic signed [MID_BITS-1:0] r6_wx, r6_wy;

    assign rot_x = (65'(r5_xc) - 65'(r5_ys)) >>> 22;
    assign rot_y = (65'(r5_xs) + 65'(r5_yc)) >>> 22;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_wx <= sat_mid(SAT_IN_W'(rot_x) + SAT_IN_W'(r5_px));
            r6_wy <= sat_mid(SAT_IN_W'(rot_y) + SAT_IN_W'(r5_py));
        end
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (en) begin
            r6_v <= r5_v;
        end
    end

    // stage 7: camera offset, operands for the view divide
    logic signed [MID_BITS-1:0] dx, dy;
    logic [MID_BITS-1:0]        mdx, mdy;
    logic [31:0]                msx, msy;
    logic                       r7_v;
    logic [D1_W-1:0]            r7_num [2];
    logic [31:0]                r7_den [2];
    logic [1:0]                 r7_neg;

    assign dx  = sat_mid(SAT_IN_W'(r6_wx) - SAT_IN_W'(r_cam_px));
    assign dy  = sat_mid(SAT_IN_W'(r6_wy) - SAT_IN_W'(r_cam_py));
    assign mdx = dx[MID_BITS-1] ? -dx : dx;
    assign mdy = dy[MID_BITS-1] ? -dy : dy;
    assign msx = r_cam_sx[31] ? -r_cam_sx : r_cam_sx;
    assign msy = r_cam_sy[31] ? -r_cam_sy : r_cam_sy;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_num[0] <= {mdx, {FRAC_BITS{1'b0}}};
            r7_num[1] <= {mdy, {FRAC_BITS{1'b0}}};
            r7_den[0] <= msx;
            r7_den[1] <= msy;
            r7_neg    <= {dy[MID_BITS-1] ^ r_cam_sy[31], dx[MID_BITS-1] ^ r_cam_sx[31]};
        end
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else if (en) begin
            r7_v <= r6_v;
        end
    end

    logic            d1_v;
    logic [D1_W-1:0] d1_q [2];
    logic [1:0]      d1_neg;

    pwst_div #(
        .DW  (D1_W),
        .VW  (32),
        .SW  (2),
        .RPS (DIV_RPS)
    ) u_div_view (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r7_v),
        .i_num   (r7_num),
        .i_den   (r7_den),
        .i_side  (r7_neg),
        .o_valid (d1_v),
        .o_quot  (d1_q),
        .o_side  (d1_neg)
    );

    // stage 8: signed view point
    logic signed [D1_W+1:0]     q1x, q1y;
    logic                       r8_v;
    logic signed [MID_BITS-1:0] r8_vx, r8_vy;

    assign q1x = d1_neg[0] ? -$signed({2'b00, d1_q[0]}) : $signed({2'b00, d1_q[0]});
    assign q1y = d1_neg[1] ? -$signed({2'b00, d1_q[1]}) : $signed({2'b00, d1_q[1]});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_vx <= sat_mid(SAT_IN_W'(q1x));
            r8_vy <= sat_mid(SAT_IN_W'(q1y));
        end
        if (!i_rst_n) begin
            r8_v <= 1'b0;
        end else if (en) begin
            r8_v <= d1_v;
        end
    end

    // stage 9: viewport scale operands
    logic [MID_BITS-1:0] mvx, mvy;
    logic [VIEW_W-2:0]   half_w, half_h;
    logic                r9_v;
    logic [D2_W-1:0]     r9_num [2];
    logic [VIEW_W-1:0]   r9_den [2];
    logic [1:0]          r9_neg;

    assign mvx    = r8_vx[MID_BITS-1] ? -r8_vx : r8_vx;
    assign mvy    = r8_vy[MID_BITS-1] ? -r8_vy : r8_vy;
    assign half_w = (r_view_w[VIEW_W-1:1] == '0) ? (VIEW_W-1)'(1) : r_view_w[VIEW_W-1:1];
    assign half_h = (r_view_h[VIEW_W-1:1] == '0) ? (VIEW_W-1)'(1) : r_view_h[VIEW_W-1:1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r9_num[0] <= D2_W'(mvx) * D2_W'(r_view_w);
            r9_num[1] <= D2_W'(mvy) * D2_W'(r_view_h);
            r9_den[0] <= {half_w, 1'b0};
            r9_den[1] <= {half_h, 1'b0};
            r9_neg    <= {r8_vy[MID_BITS-1], r8_vx[MID_BITS-1]};
        end
        if (!i_rst_n) begin
            r9_v <= 1'b0;
        end else if (en) begin
            r9_v <= r8_v;
        end
    end

    logic            d2_v;
    logic [D2_W-1:0] d2_q [2];
    logic [1:0]      d2_neg;

    pwst_div #(
        .DW  (D2_W),
        .VW  (VIEW_W),
        .SW  (2),
        .RPS (DIV_RPS)
    ) u_div_port (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r9_v),
        .i_num   (r9_num),
        .i_den   (r9_den),
        .i_side  (r9_neg),
        .o_valid (d2_v),
        .o_quot  (d2_q),
        .o_side  (d2_neg)
    );

    // stage 10: screen point
    logic signed [D2_W+1:0]     q2x, q2y;
    logic signed [SAT_IN_W-1:0] off_w, off_h;
    logic                       singular;
    logic                       r10_v;
    logic signed [31:0]         r10_sx, r10_sy;
    logic                       r10_sing;

    assign q2x      = d2_neg[0] ? -$signed({2'b00, d2_q[0]}) : $signed({2'b00, d2_q[0]});
    assign q2y      = d2_neg[1] ? -$signed({2'b00, d2_q[1]}) : $signed({2'b00, d2_q[1]});
    assign off_w    = $signed(SAT_IN_W'(r_view_w) << (FRAC_BITS - 1));
    assign off_h    = $signed(SAT_IN_W'(r_view_h) << (FRAC_BITS - 1));
    assign singular = (r_cam_sx == '0) || (r_cam_sy == '0);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r10_sing <= singular;
            r10_sx   <= singular ? '0 : sat_out(SAT_IN_W'(q2x) + off_w);
            r10_sy   <= singular ? '0 : sat_out(off_h - SAT_IN_W'(q2y));
        end
        if (!i_rst_n) begin
            r10_v <= 1'b0;
        end else if (en) begin
            r10_v <= d2_v;
        end
    end

    // output register and skid entry
    logic                   r_out_v;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic                   r_out_sing;
    logic [OUT_TDATA_W-1:0] r_skid_data;
    logic                   r_skid_sing;
    logic                   take;

    assign take = r_out_v & i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (take) begin
                r_out_data <= r_skid_data;
                r_out_sing <= r_skid_sing;
            end
        end else if (r10_v && (!r_out_v || take)) begin
            r_out_data <= {r10_sy, r10_sx};
            r_out_sing <= r10_sing;
        end else if (r10_v) begin
            r_skid_data <= {r10_sy, r10_sx};
            r_skid_sing <= r10_sing;
        end
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (take) begin
                r_skid_v <= 1'b0;
            end
        end else if (r10_v) begin
            r_out_v  <= 1'b1;
            r_skid_v <= r_out_v && !take;
        end else if (take) begin
            r_out_v <= 1'b0;
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_sing;

endmodule
`default_nettype wire

// ===== hw/rtl/pwst_check.sv =====
// Port-level checker for the point world-to-screen transform, with its bind.
// Depends on point_world_to_screen_transform_assert.svh and the top level.
`default_nettype none
`include "point_world_to_screen_transform_assert.svh"
module pwst_check (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_s_axis_tready,
    input wire        o_m_axis_tvalid,
    input wire        i_m_axis_tready,
    input wire [63:0] o_m_axis_tdata,
    input wire [0:0]  o_m_axis_tuser
);

    `PWST_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
    `PWST_ASSERT_NOW(a_singular_zero, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser[0], o_m_axis_tdata == 64'd0)
    `PWST_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, !o_s_axis_tready, $past(o_m_axis_tvalid && !i_m_axis_tready))
    `PWST_ASSERT_NEXT_ALWAYS(a_reset_idle, i_clk, !i_rst_n, !o_m_axis_tvalid && o_s_axis_tready)

endmodule

bind point_world_to_screen_transform pwst_check u_pwst_check (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
`default_nettype wire

// ===== tb/tb.sv =====
// Testbench for point_world_to_screen_transform: streams local points with random gaps
// and output stalls, predicts each screen point in fixed point and compares results.
// Depends on pwst_pkg and the block's RTL.
`timescale 1ns / 1ps
module tb;
    import pwst_pkg::*;

    localparam int           LIMIT_CYCLES   = 400000;
    localparam int           DRAIN_CYCLES   = 100;
    localparam logic [2:0]   CFG_IDX_SPARE0 = 3'd6;
    localparam logic [2:0]   CFG_IDX_SPARE1 = 3'd7;

    typedef struct {
        logic signed [31:0] lx;
        logic signed [31:0] ly;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [17:0] rot;
        logic signed [31:0] px;
        logic signed [31:0] py;
    } t_point_req;

    typedef struct {
        logic signed [31:0] scr_x;
        logic signed [31:0] scr_y;
        logic               singular;
    } t_screen_pt;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_s_axis_tvalid;
    logic                    o_s_axis_tready;
    logic [IN_TDATA_W-1:0]   i_s_axis_tdata;
    logic                    o_m_axis_tvalid;
    logic                    i_m_axis_tready;
    logic [OUT_TDATA_W-1:0]  o_m_axis_tdata;
    logic [0:0]              o_m_axis_tuser;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_idx;
    logic [CFG_DATA_W-1:0]   i_cfg_data;

    point_world_to_screen_transform dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    logic signed [31:0] cam_scale_x, cam_scale_y, cam_pos_x, cam_pos_y;
    logic [VIEW_W-1:0]  win_w, win_h;

    t_screen_pt pending_screen[$];
    int         n_errors;
    int         n_sent;
    int         n_checked;
    int         n_singular;
    int         cycle_count;
    bit         calm;

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     pending_screen.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic longint clip(input longint v, input int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function automatic longint pixel_map(input longint v, input longint size);
        longint half;
        half = size >>> 1;
        if (half == 0) half = 1;
        return (v * size) / (2 * half);
    endfunction

    function automatic t_screen_pt project_point(input t_point_req r);
        longint     arctan[16];
        longint     t, x, y, dx, dy, c, s;
        longint     ax, ay, wx, wy, vx, vy, w, h;
        bit         flip;
        t_screen_pt res;
        arctan = '{210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
                   4193963, 2097109, 1048571, 524287, 262144, 131072,
                   65536, 32768, 16384, 8192};
        res = '{0, 0, 1'b1};
        if (cam_scale_x == 0 || cam_scale_y == 0) return res;
        t = (longint'(r.rot) * longint'(THETA_K)) >>> FRAC_BITS;
        t = t - (t / TWO_PI_Q) * TWO_PI_Q;
        if (t > PI_Q) t = t - TWO_PI_Q;
        else if (t < -PI_Q) t = t + TWO_PI_Q;
        flip = 1'b0;
        if (t > HALF_PI_Q) begin
            t = t - PI_Q;
            flip = 1'b1;
        end else if (t < -HALF_PI_Q) begin
            t = t + PI_Q;
            flip = 1'b1;
        end
        x = longint'(CORDIC_GAIN);
        y = 0;
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (t >= 0) begin
                x = x - dx;
                y = y + dy;
                t = t - arctan[i];
            end else begin
                x = x + dx;
                y = y - dy;
                t = t + arctan[i];
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = x >>> 6;
        s = y >>> 6;
        ax = clip((longint'(r.lx) * longint'(r.sx)) >>> FRAC_BITS, MID_BITS);
        ay = clip((longint'(r.ly) * longint'(r.sy)) >>> FRAC_BITS, MID_BITS);
        wx = clip(((ax * c - ay * s) >>> 22) + longint'(r.px), MID_BITS);
        wy = clip(((ax * s + ay * c) >>> 22) + longint'(r.py), MID_BITS);
        vx = clip((clip(wx - longint'(cam_pos_x), MID_BITS) <<< FRAC_BITS)
                  / longint'(cam_scale_x), MID_BITS);
        vy = clip((clip(wy - longint'(cam_pos_y), MID_BITS) <<< FRAC_BITS)
                  / longint'(cam_scale_y), MID_BITS);
        w = longint'(win_w);
        h = longint'(win_h);
        res.scr_x = 32'(clip(pixel_map(vx, w) + w * (longint'(1) <<< (FRAC_BITS - 1)), 32));
        res.scr_y = 32'(clip(h * (longint'(1) <<< (FRAC_BITS - 1)) - pixel_map(vy, h), 32));
        res.singular = 1'b0;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("ERROR result %0d: %s got %0d expected %0d", n_checked, what, got, want);
        n_errors++;
    endtask

    // one point request, random gap first
    task automatic send_point(input t_point_req r);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {6'b0, r.py, r.px, r.rot, r.sy, r.sx, r.ly, r.lx};
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_screen.push_back(project_point(r));
        n_sent++;
    endtask

    // hold the sender until every pending result is back
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (pending_screen.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_CAM_SCALE_X: cam_scale_x = val;
            CFG_CAM_SCALE_Y: cam_scale_y = val;
            CFG_CAM_POS_X:   cam_pos_x = val;
            CFG_CAM_POS_Y:   cam_pos_y = val;
            CFG_VIEW_W:      win_w = val[VIEW_W-1:0];
            CFG_VIEW_H:      win_h = val[VIEW_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_camera(input logic [31:0] scx, input logic [31:0] scy,
                              input logic [31:0] pcx, input logic [31:0] pcy,
                              input logic [31:0] ww, input logic [31:0] wh);
        drain();
        cfg_write(CFG_CAM_SCALE_X, scx);
        cfg_write(CFG_CAM_SCALE_Y, scy);
        cfg_write(CFG_CAM_POS_X, pcx);
        cfg_write(CFG_CAM_POS_Y, pcy);
        cfg_write(CFG_VIEW_W, ww);
        cfg_write(CFG_VIEW_H, wh);
    endtask

    function automatic logic [31:0] rand_near(input int span);
        return 32'($urandom_range(0, 2 * span)) - 32'(span);
    endfunction

    // mostly plausible geometry; the rest raw 32 bit noise
    function automatic t_point_req rand_point();
        t_point_req r;
        r.rot = 18'($urandom);
        if ($urandom_range(0, 3) == 0) begin
            r.lx = $urandom; r.ly = $urandom; r.sx = $urandom;
            r.sy = $urandom; r.px = $urandom; r.py = $urandom;
        end else begin
            r.lx = rand_near(1 << 24); r.ly = rand_near(1 << 24);
            r.sx = rand_near(1 << 18); r.sy = rand_near(1 << 18);
            r.px = rand_near(1 << 26); r.py = rand_near(1 << 26);
        end
        return r;
    endfunction

    task automatic test_directed();
        t_point_req r;
        logic signed [31:0] ext[4];
        ext = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0001_0000, 32'sh0};
        for (int i = 0; i < 4; i++) begin
            r = '{ext[i], ext[3-i], ext[i], ext[(i+1)%4], 18'sh1ffff, ext[i], ext[3-i]};
            send_point(r);
            r.rot = 18'sh20000;
            send_point(r);
        end
        // screen point: zero local point, various rotations
        for (int i = 0; i < 8; i++) begin
            r = '{0, 0, 32'sh0001_0000, 32'sh0001_0000, 18'(i * 16384),
                  rand_near(1 << 26), rand_near(1 << 26)};
            send_point(r);
        end
        r = '{32'sh0001_0000, 32'sh0002_0000, 32'sh0001_0000, 32'sh0001_0000, 18'sd0,
              0, 0};
        send_point(r);
        r.rot = 18'sh10000;
        send_point(r);
        r.rot = 18'sh08000;
        send_point(r);
        r.rot = -18'sh08000;
        send_point(r);
    endtask

    task automatic test_singular_camera();
        set_camera(32'd0, 32'h0001_0000, 32'd0, 32'd0, 32'd640, 32'd480);
        repeat (8) send_point(rand_point());
        set_camera(32'h0002_0000, 32'd0, rand_near(1 << 20), rand_near(1 << 20), 32'd640,
                   32'd480);
        repeat (8) send_point(rand_point());
    endtask

    task automatic test_window_extremes();
        logic [31:0] sizes[6];
        sizes = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd8192, 32'h3fff};
        for (int i = 0; i < 6; i++) begin
            set_camera(32'h0001_0000, 32'hffff_0000, 32'd0, 32'd0, sizes[i], sizes[5-i]);
            repeat (10) send_point(rand_point());
        end
        set_camera(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'd8191,
                   32'd2);
        repeat (10) send_point(rand_point());
        set_camera(32'd1, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'd2, 32'd8192);
        repeat (10) send_point(rand_point());
        // spare indexes must leave the camera alone
        drain();
        cfg_write(CFG_IDX_SPARE0, $urandom);
        cfg_write(CFG_IDX_SPARE1, $urandom);
        repeat (10) send_point(rand_point());
    endtask

    task automatic test_random_stream();
        logic [31:0] s0, s1;
        for (int ph = 0; ph < 10; ph++) begin
            s0 = (ph == 7) ? 32'($urandom) : rand_near(1 << 18);
            s1 = (ph == 7) ? 32'($urandom) : rand_near(1 << 18);
            if (s0 == 0) s0 = 1;
            if (s1 == 0) s1 = 1;
            set_camera(s0, s1, rand_near(1 << 26), rand_near(1 << 26),
                       $urandom_range(2, 8192), $urandom_range(2, 8192));
            calm = (ph % 3 == 1);
            for (int i = 0; i < 110; i++) begin
                send_point(rand_point());
                if (ph == 4 && i == 50) drain();
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 18);
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
            if (pending_screen.size() == 0) begin
                report_mismatch("unexpected result", $signed(o_m_axis_tdata[31:0]), 0);
            end else begin
                t_screen_pt e;
                e = pending_screen.pop_front();
                if (o_m_axis_tuser[0] != e.singular)
                    report_mismatch("camera_singular", o_m_axis_tuser[0], e.singular);
                if ($signed(o_m_axis_tdata[31:0]) != e.scr_x)
                    report_mismatch("screen_x", $signed(o_m_axis_tdata[31:0]), e.scr_x);
                if ($signed(o_m_axis_tdata[63:32]) != e.scr_y)
                    report_mismatch("screen_y", $signed(o_m_axis_tdata[63:32]), e.scr_y);
                if (e.singular) n_singular++;
            end
            n_checked++;
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_m_axis_tready <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= CFG_CAM_SCALE_X;
        i_cfg_data      <= '0;
        cycle_count = 0;
        n_errors = 0;
        n_sent = 0;
        n_checked = 0;
        n_singular = 0;
        calm = 1'b0;
        cam_scale_x = RST_CAM_SCALE;
        cam_scale_y = RST_CAM_SCALE;
        cam_pos_x = RST_CAM_POS;
        cam_pos_y = RST_CAM_POS;
        win_w = RST_VIEW_W;
        win_h = RST_VIEW_H;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_singular_camera();
        test_window_extremes();
        test_random_stream();

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("%0d points sent, %0d results checked (%0d singular) over many camera",
                 n_sent, n_checked, n_singular);
        $display("and window settings, including zero scales and tiny or huge windows");
        if (n_errors == 0 && pending_screen.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
